// ----- hw/rtl/kway_merge_sorter_unit_defines.svh -----
// ----------------------------------------------------------------------------
// kway merge sorter assertion macros
// shared concurrent assertion forms for the merge sorter rtl
// ----------------------------------------------------------------------------
`ifndef KWAY_MERGE_SORTER_UNIT_DEFINES_SVH
`define KWAY_MERGE_SORTER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define KMS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kms assertion failed");
`define KMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kms assertion failed");
`else
`define KMS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define KMS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- hw/rtl/kms_pkg.sv -----
// ----------------------------------------------------------------------------
// kms_pkg
// types, sizes and ordering function of the k-way merge sorter
// ----------------------------------------------------------------------------
package kms_pkg;

  localparam int MAX_ITEMS  = 64;
  localparam int NUM_LISTS  = 8;
  localparam int TAG_BITS   = 3;
  localparam int VALUE_BITS = 32;

  typedef struct packed {
    logic [TAG_BITS-1:0]          list_tag;
    logic signed [VALUE_BITS-1:0] value;
    logic                         last_item;
  } kms_in_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] sorted_value;
    logic [TAG_BITS-1:0]          source_tag;
    logic                         end_of_run;
  } kms_out_t;

  // what one cell shows its neighbors
  typedef struct packed {
    logic                         full;
    logic                         cond;
    logic signed [VALUE_BITS-1:0] value;
    logic [TAG_BITS-1:0]          tag;
  } kms_link_t;

  // broadcast from the control to every cell
  typedef struct packed {
    logic                         ins;
    logic                         shift;
    logic signed [VALUE_BITS-1:0] value;
    logic [TAG_BITS-1:0]          tag;
  } kms_ctrl_t;

  // true if item a must come out before item b
  function automatic logic kms_before(input logic signed [VALUE_BITS-1:0] a_val,
                                      input logic [TAG_BITS-1:0] a_tag,
                                      input logic signed [VALUE_BITS-1:0] b_val,
                                      input logic [TAG_BITS-1:0] b_tag);
    logic res;
    if (a_val != b_val) begin
      res = (a_val < b_val);
    end else begin
      res = (a_tag < b_tag);
    end
    return res;
  endfunction

endpackage

// ----- hw/rtl/kms_cell.sv -----
// ----------------------------------------------------------------------------
// kms_cell
// one sorted storage cell: insert by compare, shift up on insert, shift down
// on drain
// ----------------------------------------------------------------------------
module kms_cell
  import kms_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  kms_ctrl_t ctrl,
  input  kms_link_t prev,
  input  kms_link_t next,
  output kms_link_t self
);

  logic                         full_r;
  logic                         full_nxt;
  logic signed [VALUE_BITS-1:0] value_r;
  logic signed [VALUE_BITS-1:0] value_nxt;
  logic [TAG_BITS-1:0]          tag_r;
  logic [TAG_BITS-1:0]          tag_nxt;
  logic                         cond;

  assign cond = !full_r || kms_before(ctrl.value, ctrl.tag, value_r, tag_r);

  always_comb begin
    full_nxt  = full_r;
    value_nxt = value_r;
    tag_nxt   = tag_r;
    priority if (ctrl.shift) begin
      full_nxt  = next.full;
      value_nxt = next.value;
      tag_nxt   = next.tag;
    end else if (ctrl.ins) begin
      full_nxt = full_r | prev.full;
      if (cond && !prev.cond) begin
        value_nxt = ctrl.value;
        tag_nxt   = ctrl.tag;
      end else if (cond) begin
        value_nxt = prev.value;
        tag_nxt   = prev.tag;
      end
    end else begin
      full_nxt  = full_r;
      value_nxt = value_r;
      tag_nxt   = tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else begin
      full_r <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    tag_r   <= tag_nxt;
  end

  assign self.full  = full_r;
  assign self.cond  = cond;
  assign self.value = value_r;
  assign self.tag   = tag_r;

endmodule

// ----- hw/rtl/kway_merge_sorter_unit.sv -----
// timing: a stored run starts in the cycle after the transfer of the last item,
// then one value per cycle while out_stall is low
// throughput: one item per cycle while loading; input stalls during the drain,
// which leaves through the single drain path at the head cell
// reset: synchronous active-low rst_n empties every cell and ends any drain
// ----------------------------------------------------------------------------
// kway_merge_sorter_unit
// k-way merge sorter built as a chain of sorted insertion cells
// ----------------------------------------------------------------------------
`include "kway_merge_sorter_unit_defines.svh"

module kway_merge_sorter_unit
  import kms_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  kms_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output kms_out_t out_data
);

  localparam kms_link_t HEAD_LINK = '{full: 1'b1, cond: 1'b0, value: '0, tag: '0};
  localparam kms_link_t TAIL_LINK = '{full: 1'b0, cond: 1'b1, value: '0, tag: '0};

  kms_link_t link [MAX_ITEMS];
  kms_ctrl_t ctrl;
  logic      drain_r;
  logic      drain_nxt;
  logic      in_xfer;
  logic      tag_ok;

  assign in_stall = drain_r;
  assign in_xfer  = in_valid && !in_stall;
  assign tag_ok   = (int'(in_data.list_tag) < NUM_LISTS);

  assign ctrl.ins   = in_xfer && tag_ok && !link[MAX_ITEMS-1].full;
  assign ctrl.shift = drain_r && link[0].full && !out_stall;
  assign ctrl.value = in_data.value;
  assign ctrl.tag   = in_data.list_tag;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    kms_link_t prev_link;
    kms_link_t next_link;
    if (i == 0) begin : g_head
      assign prev_link = HEAD_LINK;
    end else begin : g_mid_prev
      assign prev_link = link[i-1];
    end
    if (i == MAX_ITEMS - 1) begin : g_tail
      assign next_link = TAIL_LINK;
    end else begin : g_mid_next
      assign next_link = link[i+1];
    end
    kms_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .ctrl (ctrl),
      .prev (prev_link),
      .next (next_link),
      .self (link[i])
    );
  end

  always_comb begin
    drain_nxt = drain_r;
    priority if (in_xfer && in_data.last_item) begin
      drain_nxt = 1'b1;
    end else if (drain_r && !link[0].full) begin
      drain_nxt = 1'b0;
    end else begin
      drain_nxt = drain_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drain_r <= 1'b0;
    end else begin
      drain_r <= drain_nxt;
    end
  end

  assign out_valid             = drain_r && link[0].full;
  assign out_data.sorted_value = link[0].value;
  assign out_data.source_tag   = link[0].tag;
  assign out_data.end_of_run   = !link[1].full;

  `KMS_ASSERT_SAME(a_prefix_full, clk, rst_n, link[1].full, link[0].full)
  `KMS_ASSERT_NEXT(a_last_starts_drain, clk, rst_n, in_xfer && in_data.last_item, in_stall)
  `KMS_ASSERT_NEXT(a_run_ends, clk, rst_n, out_valid && !out_stall && out_data.end_of_run,
                   !out_valid)
  `KMS_ASSERT_SAME(a_no_out_while_loading, clk, rst_n, !in_stall, !out_valid)

endmodule
